// ----- src/gwbm_pkg.sv -----
package gwbm_pkg;

  localparam int unsigned IdW     = 6;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CountW  = 6;

  // a run pass never makes more new pairs than this
  localparam logic [CountW-1:0] MaxPairsPerPass = 6'd32;

  typedef enum logic [1:0] {
    CmdAddReq  = 2'd0,
    CmdAddRes  = 2'd1,
    CmdAddEdge = 2'd2,
    CmdRun     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [IdW-1:0]     rq_id;
    logic [IdW-1:0]     rs_id;
    logic [WeightW-1:0] weight;
  } in_t;

  typedef struct packed {
    logic              pair_valid;
    logic [IdW-1:0]    paired_request;
    logic [IdW-1:0]    paired_resource;
    logic [CountW-1:0] match_total;
    logic              last;
  } out_t;

  // adjacency row access: rd reads a row, set reads then ORs one bit back
  typedef struct packed {
    logic rd;
    logic set;
  } adj_op_t;

  // one candidate request per cycle into the best-weight tracker
  typedef struct packed {
    logic               clear;
    logic               cand_vld;
    logic [WeightW-1:0] cand_w;
    logic [IdW-1:0]     cand_id;
  } cmp_ctrl_t;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StEdge    = 7'b0000010,
    StResChk  = 7'b0000100,
    StResWait = 7'b0001000,
    StScan    = 7'b0010000,
    StDecide  = 7'b0100000,
    StFinal   = 7'b1000000
  } state_e;

endpackage

// ----- src/gwbm_adj.sv -----
module gwbm_adj import gwbm_pkg::*; #(
  parameter int ID_SPACE = 64,
  localparam int IdxW = $clog2(ID_SPACE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adj_op_t             op_i,
  input  logic [IdxW-1:0]     row_i,
  input  logic [IdxW-1:0]     col_i,
  output logic [ID_SPACE-1:0] row_o
);

  // one row per resource id, one bit per request id
  logic [ID_SPACE-1:0] mem [ID_SPACE];
  logic [ID_SPACE-1:0] row_vld_q;
  logic [ID_SPACE-1:0] rd_data_q;
  logic                rd_vld_q;
  logic                pend_q;
  logic [IdxW-1:0]     pend_row_q;
  logic [IdxW-1:0]     pend_col_q;
  logic [ID_SPACE-1:0] wdata;
  logic                rd_en;

  assign rd_en = op_i.rd || op_i.set;
  // rows never written read as empty
  assign row_o = rd_vld_q ? rd_data_q : '0;
  assign wdata = row_o | (ID_SPACE'(1) << pend_col_q);

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[pend_row_q] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[row_i];
    end
    if (op_i.set) begin
      pend_row_q <= row_i;
      pend_col_q <= col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      pend_q <= op_i.set;
      if (rd_en) begin
        rd_vld_q <= row_vld_q[row_i];
      end
      if (pend_q) begin
        row_vld_q[pend_row_q] <= 1'b1;
      end
    end
  end

endmodule

// ----- src/gwbm_best.sv -----
module gwbm_best import gwbm_pkg::*; #(
  parameter int LIST_DEPTH = 32,
  localparam int LiW = $clog2(LIST_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmp_ctrl_t      ctrl_i,
  input  logic [LiW-1:0] cand_idx_i,
  output logic           found_o,
  output logic [LiW-1:0] best_idx_o,
  output logic [IdW-1:0] best_id_o
);

  logic               found_q;
  logic [WeightW-1:0] best_w_q;
  logic [LiW-1:0]     best_idx_q;
  logic [IdW-1:0]     best_id_q;
  logic               take;

  // strict greater: on a tie the earlier request keeps the slot
  assign take = ctrl_i.cand_vld && (!found_q || (ctrl_i.cand_w > best_w_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && take) begin
      best_w_q   <= ctrl_i.cand_w;
      best_idx_q <= cand_idx_i;
      best_id_q  <= ctrl_i.cand_id;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_id_o  = best_id_q;

endmodule

// ----- src/greedy_weighted_bipartite_matcher_core.sv -----
// Greedy weighted bipartite matcher.
// Command channel: a word on cmd_i is taken when start is high and busy is low.
//   add request / add resource: stored in the same cycle, busy stays low.
//   add edge: with both ids in id space, sets one bit of the adjacency row memory; busy while the row is written back.
//   run: walks the resource list in load order; for each free resource with
//     an in-range id, the request list is scanned one entry per cycle through
//     a single weight comparator, and the heaviest free adjacent request wins.
// Result channel: res_valid_o strobes one word for one cycle per new pair,
// then one word with last set and the running match total. The receiver
// cannot stall; results are never held.
// Run steps, per resource index: a taken one is skipped; else its id is read,
// and an id out of id space is skipped; else its adjacency row is read, the
// request list is read entry by entry and the compare drained, then decide.
// The request-list scan through the one comparator dominates the run time.
// After the last index, or once a pass made MaxPairsPerPass pairs, the closing word follows.
// The last word shows in the first idle cycle, so a new start may be taken
// then. Reset empties both lists, the edges and the match count; the
// adjacency memory is tracked by per-row valid bits, so no clearing pass.
module greedy_weighted_bipartite_matcher_core import gwbm_pkg::*; #(
  parameter int LIST_DEPTH = 32,
  parameter int ID_SPACE   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  cmd_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int LiW  = $clog2(LIST_DEPTH);
  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int IdxW = $clog2(ID_SPACE);

  function automatic logic in_space(input logic [IdW-1:0] id);
    return 32'(id) < 32'(ID_SPACE);
  endfunction

  state_e                state_q, state_d;
  logic [CntW-1:0]       req_cnt_q, req_cnt_d;
  logic [CntW-1:0]       res_cnt_q, res_cnt_d;
  logic [CntW-1:0]       i_q, i_d;
  logic [CntW-1:0]       j_q, j_d;
  logic                  pv_q, pv_d;
  logic [LiW-1:0]        pidx_q, pidx_d;
  logic [CountW-1:0]     pass_q, pass_d;
  logic [CountW-1:0]     pair_cnt_q, pair_cnt_d;
  logic [LIST_DEPTH-1:0] req_taken_q, req_taken_d;
  logic [LIST_DEPTH-1:0] res_taken_q, res_taken_d;
  logic                  vld_q, vld_d;
  out_t                  out_q, out_d;

  logic [IdW-1:0]     req_id_mem [LIST_DEPTH];
  logic [WeightW-1:0] req_w_mem  [LIST_DEPTH];
  logic [IdW-1:0]     res_id_mem [LIST_DEPTH];
  logic [IdW-1:0]     req_rd_id_q;
  logic [WeightW-1:0] req_rd_w_q;
  logic [IdW-1:0]     res_rd_id_q;
  logic               req_we, res_we, req_re, res_re;
  logic               accept;
  logic               issue;

  adj_op_t             adj_op;
  logic [IdxW-1:0]     adj_row, adj_col;
  logic [ID_SPACE-1:0] adj_data;

  cmp_ctrl_t      cmp;
  logic           found;
  logic [LiW-1:0] best_idx;
  logic [IdW-1:0] best_id;

  gwbm_adj #(
    .ID_SPACE(ID_SPACE)
  ) u_adj (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (adj_op),
    .row_i (adj_row),
    .col_i (adj_col),
    .row_o (adj_data)
  );

  gwbm_best #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_best (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cmp),
    .cand_idx_i(pidx_q),
    .found_o   (found),
    .best_idx_o(best_idx),
    .best_id_o (best_id)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign issue  = (j_q < req_cnt_q);

  always_comb begin
    state_d     = state_q;
    req_cnt_d   = req_cnt_q;
    res_cnt_d   = res_cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    pass_d      = pass_q;
    pair_cnt_d  = pair_cnt_q;
    req_taken_d = req_taken_q;
    res_taken_d = res_taken_q;
    vld_d       = 1'b0;
    out_d       = '0;
    req_we      = 1'b0;
    res_we      = 1'b0;
    req_re      = 1'b0;
    res_re      = 1'b0;
    adj_op      = '0;
    adj_row     = '0;
    adj_col     = '0;
    cmp         = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (cmd_i.command)
            CmdAddReq: begin
              if (req_cnt_q < CntW'(LIST_DEPTH)) begin
                req_we                         = 1'b1;
                req_taken_d[req_cnt_q[LiW-1:0]] = 1'b0;
                req_cnt_d                      = req_cnt_q + CntW'(1);
              end
            end
            CmdAddRes: begin
              if (res_cnt_q < CntW'(LIST_DEPTH)) begin
                res_we                         = 1'b1;
                res_taken_d[res_cnt_q[LiW-1:0]] = 1'b0;
                res_cnt_d                      = res_cnt_q + CntW'(1);
              end
            end
            CmdAddEdge: begin
              if (in_space(cmd_i.rq_id) && in_space(cmd_i.rs_id)) begin
                adj_op.set = 1'b1;
                adj_row    = IdxW'(cmd_i.rs_id);
                adj_col    = IdxW'(cmd_i.rq_id);
                state_d    = StEdge;
              end
            end
            CmdRun: begin
              i_d     = '0;
              pass_d  = '0;
              state_d = StResChk;
            end
          endcase
        end
      end
      StEdge: begin
        // row write-back happens in this cycle
        state_d = StIdle;
      end
      StResChk: begin
        if ((i_q >= res_cnt_q) || (pass_q == MaxPairsPerPass)) begin
          state_d = StFinal;
        end else if (res_taken_q[i_q[LiW-1:0]]) begin
          i_d = i_q + CntW'(1);
        end else begin
          res_re  = 1'b1;
          state_d = StResWait;
        end
      end
      StResWait: begin
        if (in_space(res_rd_id_q)) begin
          adj_op.rd = 1'b1;
          adj_row   = IdxW'(res_rd_id_q);
          cmp.clear = 1'b1;
          j_d       = '0;
          state_d   = StScan;
        end else begin
          // resource id outside the id space has no edges
          i_d     = i_q + CntW'(1);
          state_d = StResChk;
        end
      end
      StScan: begin
        // read request j this cycle, judge it the next
        if (issue) begin
          req_re = 1'b1;
          j_d    = j_q + CntW'(1);
          pv_d   = 1'b1;
          pidx_d = j_q[LiW-1:0];
        end
        cmp.cand_vld = pv_q && !req_taken_q[pidx_q] && in_space(req_rd_id_q)
                       && adj_data[IdxW'(req_rd_id_q)];
        cmp.cand_w   = req_rd_w_q;
        cmp.cand_id  = req_rd_id_q;
        if (!issue && !pv_q) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (found) begin
          res_taken_d[i_q[LiW-1:0]] = 1'b1;
          req_taken_d[best_idx]     = 1'b1;
          pair_cnt_d                = pair_cnt_q + CountW'(1);
          pass_d                    = pass_q + CountW'(1);
          vld_d                     = 1'b1;
          out_d.pair_valid          = 1'b1;
          out_d.paired_request      = best_id;
          out_d.paired_resource     = res_rd_id_q;
          out_d.match_total         = pair_cnt_q + CountW'(1);
          out_d.last                = 1'b0;
        end
        i_d     = i_q + CntW'(1);
        state_d = StResChk;
      end
      StFinal: begin
        vld_d             = 1'b1;
        out_d.match_total = pair_cnt_q;
        out_d.last        = 1'b1;
        state_d           = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_cnt_q   <= '0;
      res_cnt_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      pass_q      <= '0;
      pair_cnt_q  <= '0;
      req_taken_q <= '0;
      res_taken_q <= '0;
      vld_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_cnt_q   <= req_cnt_d;
      res_cnt_q   <= res_cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pv_q        <= pv_d;
      pidx_q      <= pidx_d;
      pass_q      <= pass_d;
      pair_cnt_q  <= pair_cnt_d;
      req_taken_q <= req_taken_d;
      res_taken_q <= res_taken_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_d) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_we) begin
      req_id_mem[req_cnt_q[LiW-1:0]] <= cmd_i.rq_id;
      req_w_mem[req_cnt_q[LiW-1:0]]  <= cmd_i.weight;
    end
    if (req_re) begin
      req_rd_id_q <= req_id_mem[j_q[LiW-1:0]];
      req_rd_w_q  <= req_w_mem[j_q[LiW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_id_mem[res_cnt_q[LiW-1:0]] <= cmd_i.rs_id;
    end
    if (res_re) begin
      res_rd_id_q <= res_id_mem[i_q[LiW-1:0]];
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  a_pair_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.pair_valid |-> busy)
    else $error("pair word outside a run pass");

  a_last_ends_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy && !res_o.pair_valid)
    else $error("last word while pass still running");

  a_load_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.command == CmdAddReq || cmd_i.command == CmdAddRes)
    |=> !busy && !res_valid_o)
    else $error("list load stalled or gave a word");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.command == CmdRun |=> busy)
    else $error("run command not started");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import gwbm_pkg::*;

  localparam int ListDepth  = 32;
  localparam int IdSpace    = 64;
  localparam int ItemTarget = 170;
  localparam int CycleLimit = 800000;

  // Tracks lists, edges and matches; predicts the words that each run emits.
  class matcher_checker;
    logic [IdW-1:0]     req_ids [ListDepth];
    logic [WeightW-1:0] req_wts [ListDepth];
    bit                 req_taken [ListDepth];
    int unsigned        req_count;
    logic [IdW-1:0]     res_ids [ListDepth];
    bit                 res_taken [ListDepth];
    int unsigned        res_count;
    bit [IdSpace-1:0]   adj [IdSpace];
    int unsigned        pair_total;
    out_t               pending_words [$];
    int unsigned        errors;
    int unsigned        words_seen;

    function void note_command(in_t w);
      out_t        r;
      int unsigned made;
      bit          found;
      int unsigned best;
      case (cmd_e'(w.command))
        CmdAddReq: begin
          if (req_count < ListDepth) begin
            req_ids[req_count]   = w.rq_id;
            req_wts[req_count]   = w.weight;
            req_taken[req_count] = 1'b0;
            req_count++;
          end
        end
        CmdAddRes: begin
          if (res_count < ListDepth) begin
            res_ids[res_count]   = w.rs_id;
            res_taken[res_count] = 1'b0;
            res_count++;
          end
        end
        CmdAddEdge: begin
          if (w.rq_id < IdSpace && w.rs_id < IdSpace)
            adj[w.rq_id][w.rs_id] = 1'b1;
        end
        CmdRun: begin
          made = 0;
          for (int i = 0; i < res_count; i++) begin
            if (made >= MaxPairsPerPass) break;
            if (res_taken[i]) continue;
            found = 1'b0;
            best  = 0;
            for (int j = 0; j < req_count; j++) begin
              if (req_taken[j]) continue;
              if (req_ids[j] >= IdSpace || res_ids[i] >= IdSpace) continue;
              if (!adj[req_ids[j]][res_ids[i]]) continue;
              // strict compare: earlier load keeps the tie
              if (!found || req_wts[j] > req_wts[best]) begin
                found = 1'b1;
                best  = j;
              end
            end
            if (found) begin
              res_taken[i]      = 1'b1;
              req_taken[best]   = 1'b1;
              pair_total++;
              made++;
              r.pair_valid      = 1'b1;
              r.paired_request  = req_ids[best];
              r.paired_resource = res_ids[i];
              r.match_total     = pair_total[CountW-1:0];
              r.last            = 1'b0;
              pending_words     = {pending_words, r};
            end
          end
          r.pair_valid      = 1'b0;
          r.paired_request  = '0;
          r.paired_resource = '0;
          r.match_total     = pair_total[CountW-1:0];
          r.last            = 1'b1;
          pending_words     = {pending_words, r};
        end
      endcase
    endfunction

    function void check_word(out_t got);
      out_t want;
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("result word with none expected: %p", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.pair_valid !== want.pair_valid) begin
        $error("pair_valid: expected %0d, got %0d", want.pair_valid, got.pair_valid);
        errors++;
      end
      if (got.paired_request !== want.paired_request) begin
        $error("paired_request: expected %0d, got %0d",
               want.paired_request, got.paired_request);
        errors++;
      end
      if (got.paired_resource !== want.paired_resource) begin
        $error("paired_resource: expected %0d, got %0d",
               want.paired_resource, got.paired_resource);
        errors++;
      end
      if (got.match_total !== want.match_total) begin
        $error("match_total: expected %0d, got %0d", want.match_total, got.match_total);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  cmd_i  = '0;
  logic busy;
  logic res_valid_o;
  out_t res_o;

  matcher_checker chk;
  int unsigned    items_sent = 0;
  int unsigned    runs_sent  = 0;
  int unsigned    cycle_count = 0;
  logic [IdW-1:0] req_pool [$];
  logic [IdW-1:0] res_pool [$];

  greedy_weighted_bipartite_matcher_core #(
    .LIST_DEPTH(ListDepth),
    .ID_SPACE  (IdSpace)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** greedy_weighted_bipartite_matcher_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) chk.check_word(res_o);
  end

  function automatic logic [WeightW-1:0] pick_weight();
    // bias toward the ends and a shared value so ties show up
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return '1;
          default: return 16'h8000;
        endcase
      end
      default: return WeightW'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic send(input cmd_e op, input logic [IdW-1:0] rq, input logic [IdW-1:0] rs,
                      input logic [WeightW-1:0] wt);
    in_t w;
    int  pct;
    pct = (items_sent < 57) ? 26 : (items_sent < 114) ? 74 : 0;
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    w.command = op;
    w.rq_id   = rq;
    w.rs_id   = rs;
    w.weight  = wt;
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    chk.note_command(w);
    items_sent++;
    if (op == CmdRun) runs_sent++;
  endtask

  task automatic run_sequence();
    logic [IdW-1:0] id;
    int unsigned    n;
    n = $urandom_range(3);
    repeat (n) begin
      id = (req_pool.size() != 0 && $urandom_range(3) == 0) ?
           req_pool[$urandom_range(req_pool.size() - 1)] : IdW'($urandom_range(63));
      req_pool = {req_pool, id};
      send(CmdAddReq, id, IdW'($urandom_range(63)), pick_weight());
    end
    n = $urandom_range(3);
    repeat (n) begin
      id = (res_pool.size() != 0 && $urandom_range(3) == 0) ?
           res_pool[$urandom_range(res_pool.size() - 1)] : IdW'($urandom_range(63));
      res_pool = {res_pool, id};
      send(CmdAddRes, IdW'($urandom_range(63)), id, pick_weight());
    end
    n = $urandom_range(1, 5);
    repeat (n) begin
      if (req_pool.size() != 0 && res_pool.size() != 0 && $urandom_range(7) != 0)
        send(CmdAddEdge, req_pool[$urandom_range(req_pool.size() - 1)],
             res_pool[$urandom_range(res_pool.size() - 1)], pick_weight());
      else
        send(CmdAddEdge, IdW'($urandom_range(63)), IdW'($urandom_range(63)), pick_weight());
    end
    send(CmdRun, IdW'($urandom_range(63)), IdW'($urandom_range(63)), pick_weight());
  endtask

  initial begin
    chk = new;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty lists: a pass gives only the closing word
    send(CmdRun, 6'd0, 6'd0, 16'h0000);
    send(CmdAddReq, 6'd0, 6'd63, 16'h0000);
    send(CmdAddReq, 6'd63, 6'd0, 16'hffff);
    send(CmdAddReq, 6'd5, 6'd21, 16'h1234);
    send(CmdAddReq, 6'd7, 6'd42, 16'h1234);
    send(CmdAddReq, 6'd5, 6'd11, 16'h0001);
    send(CmdAddRes, 6'd42, 6'd0, 16'h5555);
    send(CmdAddRes, 6'd21, 6'd63, 16'haaaa);
    send(CmdAddRes, 6'd0, 6'd9, 16'h0000);
    send(CmdAddRes, 6'd63, 6'd9, 16'hffff);
    send(CmdAddEdge, 6'd0, 6'd0, 16'h0000);
    send(CmdAddEdge, 6'd63, 6'd0, 16'hffff);
    send(CmdAddEdge, 6'd0, 6'd63, 16'h0000);
    send(CmdAddEdge, 6'd5, 6'd9, 16'h8000);
    send(CmdAddEdge, 6'd7, 6'd9, 16'h7fff);
    send(CmdAddEdge, 6'd63, 6'd63, 16'hffff);
    send(CmdRun, 6'd63, 6'd63, 16'hffff);
    // nothing free is adjacent any more
    send(CmdRun, 6'd0, 6'd0, 16'h0000);
    send(CmdAddRes, 6'd0, 6'd5, 16'h0000);
    send(CmdAddEdge, 6'd5, 6'd5, 16'h0000);
    send(CmdRun, 6'd21, 6'd42, 16'h1234);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(4) == 0)
        send(cmd_e'($urandom_range(3)), IdW'($urandom_range(63)), IdW'($urandom_range(63)),
             pick_weight());
      else
        run_sequence();
    end
    send(CmdRun, 6'd0, 6'd0, 16'h0000);
    start <= 1'b0;

    while (chk.pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d commands with %0d matching passes", items_sent, runs_sent);
    $display("checked %0d result words, %0d pairs made in total",
             chk.words_seen, chk.pair_total);
    if (chk.errors == 0 && chk.pending_words.size() == 0) begin
      $display("** greedy_weighted_bipartite_matcher_core: PASSED **");
    end else begin
      $display("** greedy_weighted_bipartite_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule
